### design/drf_pkg.sv
// Shared types, address map constants and byte lane helpers for the display register file.
package drf_pkg;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 8;
    localparam int OFF_W    = 12;
    localparam int PAGE_W   = ADDR_W - OFF_W;
    localparam int IDX_W    = 4;
    localparam int BG_COUNT_DEF = 4;

    localparam logic [PAGE_W-1:0] MAIN_PAGE = 20'h04000;
    localparam logic [PAGE_W-1:0] SUB_PAGE  = 20'h04001;

    localparam logic [OFF_W-1:0] OFF_DISPCNT  = 12'h000;
    localparam logic [OFF_W-1:0] OFF_BGCNT    = 12'h008;
    localparam logic [OFF_W-1:0] OFF_BGOFS    = 12'h010;
    localparam logic [OFF_W-1:0] OFF_AFFINE   = 12'h020;
    localparam logic [OFF_W-1:0] OFF_AFF_END  = 12'h040;
    localparam logic [OFF_W-1:0] OFF_WIN      = 12'h040;
    localparam logic [OFF_W-1:0] OFF_WIN_END  = 12'h04C;
    localparam logic [OFF_W-1:0] OFF_BLEND    = 12'h050;
    localparam logic [OFF_W-1:0] OFF_BLD_END  = 12'h056;
    localparam logic [OFF_W-1:0] OFF_CAPTURE  = 12'h064;
    localparam logic [OFF_W-1:0] OFF_CAP_END  = 12'h068;
    localparam logic [OFF_W-1:0] OFF_BRIGHT   = 12'h06C;
    localparam logic [OFF_W-1:0] OFF_BRT_END  = 12'h06E;

    localparam int WIN_PER_ENG   = 6;
    localparam int BLEND_PER_ENG = 3;
    localparam int AFF_COEFF_DEPTH = 16;
    localparam int AFF_REF_DEPTH   = 8;
    localparam int WIN_DEPTH       = 12;
    localparam int BLEND_DEPTH     = 6;

    localparam logic [DATA_W-1:0] REF_TOP_MASK = 8'h0F;
    localparam logic [1:0]        REF_TOP_BYTE = 2'd3;

    typedef enum logic [3:0] {
        K_NONE,
        K_DISPCNT,
        K_BGCNT,
        K_BGHOFS,
        K_BGVOFS,
        K_AFF_COEFF,
        K_AFF_REF,
        K_WIN,
        K_BLEND,
        K_CAPTURE,
        K_BRIGHT
    } t_reg_kind;

    typedef struct packed {
        logic             mapped;
        t_reg_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [1:0]       byte_sel;
    } t_dec;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_req;

    function automatic logic [7:0] get32(input logic [31:0] v, input logic [1:0] b);
        logic [7:0] r;
        case (b)
            2'd0:    r = v[7:0];
            2'd1:    r = v[15:8];
            2'd2:    r = v[23:16];
            default: r = v[31:24];
        endcase
        return r;
    endfunction

    function automatic logic [31:0] put32(input logic [31:0] v, input logic [1:0] b,
                                          input logic [7:0] d);
        logic [31:0] r;
        r = v;
        case (b)
            2'd0:    r[7:0]   = d;
            2'd1:    r[15:8]  = d;
            2'd2:    r[23:16] = d;
            default: r[31:24] = d;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] get16(input logic [15:0] v, input logic b);
        return b ? v[15:8] : v[7:0];
    endfunction

    function automatic logic [15:0] put16(input logic [15:0] v, input logic b,
                                          input logic [7:0] d);
        return b ? {d, v[7:0]} : {v[15:8], d};
    endfunction

endpackage

### design/drf_if.sv
// Request and response channel interfaces for the display register file.
interface drf_req_if
    import drf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_byte;

    modport source (output valid, output req_type, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input req_type, input bus_address, input write_byte,
                    output ready);
endinterface

interface drf_rsp_if
    import drf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_byte;
    logic              mapped;

    modport source (output valid, output read_byte, output mapped, input ready);
    modport sink   (input valid, input read_byte, input mapped, output ready);
endinterface

### design/display_io_byte_register_file.sv
// Request beats pass the input register, then the result register, to the response side.
// One request beat per cycle while responses drain; a write is visible to the next beat.
// Backpressure on the response side holds both registers; the request side keeps
// flowing into the input register while the result register drains.
// Reset (synchronous, active low) clears all display registers to zero and
// empties both pipeline registers.
module display_io_byte_register_file
    import drf_pkg::*;
#(
    parameter int BG_COUNT = BG_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    drf_req_if.sink   i_req,
    drf_rsp_if.source o_rsp
);

    t_req              r_req;
    logic              r_in_valid;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_byte;
    logic              r_mapped;

    logic              adv;
    t_dec              dec;
    logic [DATA_W-1:0] rd;

    assign adv         = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || adv;

    drf_decode #(.BG_COUNT(BG_COUNT)) u_decode (
        .i_addr (r_req.addr),
        .o_dec  (dec)
    );

    drf_regs #(.BG_COUNT(BG_COUNT)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_in_valid && adv && r_req.wr),
        .i_dec   (dec),
        .i_data  (r_req.data),
        .o_rd    (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) r_in_valid <= i_req.valid;
            if (adv)         r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.wr   <= i_req.req_type;
            r_req.addr <= i_req.bus_address;
            r_req.data <= i_req.write_byte;
        end
        if (adv && r_in_valid) begin
            r_read_byte <= r_req.wr ? '0 : rd;
            r_mapped    <= dec.mapped;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_byte = r_read_byte;
    assign o_rsp.mapped    = r_mapped;

endmodule

### design/drf_decode.sv
// Address decoder: maps a bus address to a register kind, entry index and byte lane.
module drf_decode
    import drf_pkg::*;
#(
    parameter int BG_COUNT = BG_COUNT_DEF
) (
    input  logic [ADDR_W-1:0] i_addr,
    output t_dec              o_dec
);

    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
    logic              eng;
    logic              page_hit;
    logic [IDX_W-1:0]  bg_base;

    assign page     = i_addr[ADDR_W-1:OFF_W];
    assign off      = i_addr[OFF_W-1:0];
    assign eng      = (page == SUB_PAGE);
    assign page_hit = (page == MAIN_PAGE) || (page == SUB_PAGE);
    assign bg_base  = eng ? IDX_W'(BG_COUNT) : '0;

    always_comb begin
        o_dec          = '0;
        o_dec.kind     = K_NONE;
        o_dec.byte_sel = off[1:0];
        if (page_hit) begin
            if (off < OFF_DISPCNT + 12'd4) begin
                o_dec.kind = K_DISPCNT;
                o_dec.idx  = IDX_W'(eng);
            end else if (off >= OFF_BGCNT && off < OFF_BGOFS && int'(off[2:1]) < BG_COUNT) begin
                o_dec.kind     = K_BGCNT;
                o_dec.idx      = bg_base + IDX_W'(off[2:1]);
                o_dec.byte_sel = {1'b0, off[0]};
            end else if (off >= OFF_BGOFS && off < OFF_AFFINE && int'(off[3:2]) < BG_COUNT) begin
                o_dec.kind     = off[1] ? K_BGVOFS : K_BGHOFS;
                o_dec.idx      = bg_base + IDX_W'(off[3:2]);
                o_dec.byte_sel = {1'b0, off[0]};
            end else if (off >= OFF_AFFINE && off < OFF_AFF_END) begin
                if (!off[3]) begin
                    o_dec.kind     = K_AFF_COEFF;
                    o_dec.idx      = {eng, off[4], off[2:1]};
                    o_dec.byte_sel = {1'b0, off[0]};
                end else begin
                    o_dec.kind = K_AFF_REF;
                    o_dec.idx  = {1'b0, eng, off[4], off[2]};
                end
            end else if (off >= OFF_WIN && off < OFF_WIN_END) begin
                o_dec.kind     = K_WIN;
                o_dec.idx      = (eng ? IDX_W'(WIN_PER_ENG) : '0) + IDX_W'(off[3:1]);
                o_dec.byte_sel = {1'b0, off[0]};
            end else if (off >= OFF_BLEND && off < OFF_BLD_END) begin
                o_dec.kind     = K_BLEND;
                o_dec.idx      = (eng ? IDX_W'(BLEND_PER_ENG) : '0) + IDX_W'(off[2:1]);
                o_dec.byte_sel = {1'b0, off[0]};
            end else if (!eng && off >= OFF_CAPTURE && off < OFF_CAP_END) begin
                o_dec.kind = K_CAPTURE;
            end else if (off >= OFF_BRIGHT && off < OFF_BRT_END) begin
                o_dec.kind     = K_BRIGHT;
                o_dec.idx      = IDX_W'(eng);
                o_dec.byte_sel = {1'b0, off[0]};
            end
        end
        o_dec.mapped = (o_dec.kind != K_NONE);
    end

endmodule

### design/drf_regs.sv
// Register storage for both engines: byte-lane writes and a byte read mux.
module drf_regs
    import drf_pkg::*;
#(
    parameter int BG_COUNT = BG_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  t_dec              i_dec,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_rd
);

    localparam int BG_DEPTH = 2 * BG_COUNT;
    localparam int BG_IW    = $clog2(BG_DEPTH);

    logic [31:0] r_dispcnt   [0:1];
    logic [15:0] r_bgcnt     [0:BG_DEPTH-1];
    logic [15:0] r_bghofs    [0:BG_DEPTH-1];
    logic [15:0] r_bgvofs    [0:BG_DEPTH-1];
    logic [15:0] r_aff_coeff [0:AFF_COEFF_DEPTH-1];
    logic [31:0] r_aff_ref   [0:AFF_REF_DEPTH-1];
    logic [15:0] r_win       [0:WIN_DEPTH-1];
    logic [15:0] r_blend     [0:BLEND_DEPTH-1];
    logic [15:0] r_bright    [0:1];
    logic [31:0] r_capture;

    logic [BG_IW-1:0]  bg_idx;
    logic [2:0]        ref_idx;
    logic [2:0]        bld_idx;
    logic              eng_idx;
    logic              lane;
    logic [DATA_W-1:0] ref_data;

    assign bg_idx  = i_dec.idx[BG_IW-1:0];
    assign ref_idx = i_dec.idx[2:0];
    assign bld_idx = i_dec.idx[2:0];
    assign eng_idx = i_dec.idx[0];
    assign lane    = i_dec.byte_sel[0];
    // top byte of a reference point is only 4 bits wide
    assign ref_data = (i_dec.byte_sel == REF_TOP_BYTE) ? (i_data & REF_TOP_MASK) : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_dispcnt[i] <= '0;
                r_bright[i]  <= '0;
            end
            for (int i = 0; i < BG_DEPTH; i++) begin
                r_bgcnt[i]  <= '0;
                r_bghofs[i] <= '0;
                r_bgvofs[i] <= '0;
            end
            for (int i = 0; i < AFF_COEFF_DEPTH; i++) r_aff_coeff[i] <= '0;
            for (int i = 0; i < AFF_REF_DEPTH; i++)   r_aff_ref[i]   <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)       r_win[i]       <= '0;
            for (int i = 0; i < BLEND_DEPTH; i++)     r_blend[i]     <= '0;
            r_capture <= '0;
        end else if (i_we) begin
            case (i_dec.kind)
                K_DISPCNT:   r_dispcnt[eng_idx] <=
                                 put32(r_dispcnt[eng_idx], i_dec.byte_sel, i_data);
                K_BGCNT:     r_bgcnt[bg_idx] <= put16(r_bgcnt[bg_idx], lane, i_data);
                K_BGHOFS:    r_bghofs[bg_idx] <= put16(r_bghofs[bg_idx], lane, i_data);
                K_BGVOFS:    r_bgvofs[bg_idx] <= put16(r_bgvofs[bg_idx], lane, i_data);
                K_AFF_COEFF: r_aff_coeff[i_dec.idx] <=
                                 put16(r_aff_coeff[i_dec.idx], lane, i_data);
                K_AFF_REF:   r_aff_ref[ref_idx] <=
                                 put32(r_aff_ref[ref_idx], i_dec.byte_sel, ref_data);
                K_WIN:       r_win[i_dec.idx] <= put16(r_win[i_dec.idx], lane, i_data);
                K_BLEND:     r_blend[bld_idx] <= put16(r_blend[bld_idx], lane, i_data);
                K_CAPTURE:   r_capture <= put32(r_capture, i_dec.byte_sel, i_data);
                K_BRIGHT:    r_bright[eng_idx] <= put16(r_bright[eng_idx], lane, i_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_dec.kind)
            K_DISPCNT:   o_rd = get32(r_dispcnt[eng_idx], i_dec.byte_sel);
            K_BGCNT:     o_rd = get16(r_bgcnt[bg_idx], lane);
            K_BGHOFS:    o_rd = get16(r_bghofs[bg_idx], lane);
            K_BGVOFS:    o_rd = get16(r_bgvofs[bg_idx], lane);
            K_AFF_COEFF: o_rd = get16(r_aff_coeff[i_dec.idx], lane);
            K_AFF_REF:   o_rd = get32(r_aff_ref[ref_idx], i_dec.byte_sel);
            K_WIN:       o_rd = get16(r_win[i_dec.idx], lane);
            K_BLEND:     o_rd = get16(r_blend[bld_idx], lane);
            K_CAPTURE:   o_rd = get32(r_capture, i_dec.byte_sel);
            K_BRIGHT:    o_rd = get16(r_bright[eng_idx], lane);
            default:     o_rd = '0;
        endcase
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the display register file: directed and random byte accesses checked against a shadow copy.
module tb_top;
    import drf_pkg::*;

    localparam int NUM_BG = BG_COUNT_DEF;
    localparam bit ACC_READ  = 1'b0;
    localparam bit ACC_WRITE = 1'b1;
    localparam int RANDOM_ACCESSES = 1900;
    localparam int PRINT_LIMIT = 50;

    logic i_clk;
    logic i_rst_n;

    drf_req_if req_if ();
    drf_rsp_if rsp_if ();

    display_io_byte_register_file #(.BG_COUNT(NUM_BG)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    typedef struct {
        bit [31:0] addr;
        bit [7:0]  read_byte;
        bit        mapped;
    } t_exp_beat;

    // Shadow copy of every display register; predicts each response in accept order.
    class reg_file_shadow;
        bit [31:0] disp_ctl [2];
        bit [15:0] bg_cnt [2*NUM_BG];
        bit [15:0] bg_hofs [2*NUM_BG];
        bit [15:0] bg_vofs [2*NUM_BG];
        bit [15:0] aff_coeff [16];
        bit [31:0] aff_ref [8];
        bit [15:0] win_regs [12];
        bit [15:0] blend_regs [6];
        bit [15:0] bright [2];
        bit [31:0] cap_ctl;
        t_exp_beat pending_beats [$];
        int mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task report(input string msg);
            if (mismatch_count < PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatch_count++;
        endtask

        function int outstanding();
            return pending_beats.size();
        endfunction

        function t_reg_kind decode(input bit [31:0] addr, output int idx, output bit [1:0] lane);
            int eng;
            bit [11:0] off;
            idx  = 0;
            lane = 0;
            if (addr[31:12] == MAIN_PAGE)
                eng = 0;
            else if (addr[31:12] == SUB_PAGE)
                eng = 1;
            else
                return K_NONE;
            off = addr[11:0];
            if (off < OFF_DISPCNT + 4) begin
                idx  = eng;
                lane = off[1:0];
                return K_DISPCNT;
            end
            lane = {1'b0, off[0]};
            if (off >= OFF_BGCNT && off < OFF_BGCNT + 2*NUM_BG) begin
                idx = eng*NUM_BG + (off - OFF_BGCNT)/2;
                return K_BGCNT;
            end
            if (off >= OFF_BGOFS && off < OFF_BGOFS + 4*NUM_BG) begin
                idx = eng*NUM_BG + (off - OFF_BGOFS)/4;
                return off[1] ? K_BGVOFS : K_BGHOFS;
            end
            if (off >= OFF_AFFINE && off < OFF_AFF_END) begin
                // bit 4 picks BG2/BG3, low nibble is the offset within the block
                if (off[3:0] < 8) begin
                    idx = eng*8 + off[4]*4 + off[2:1];
                    return K_AFF_COEFF;
                end
                idx  = eng*4 + off[4]*2 + off[2];
                lane = off[1:0];
                return K_AFF_REF;
            end
            if (off >= OFF_WIN && off < OFF_WIN_END) begin
                idx = eng*WIN_PER_ENG + (off - OFF_WIN)/2;
                return K_WIN;
            end
            if (off >= OFF_BLEND && off < OFF_BLD_END) begin
                idx = eng*BLEND_PER_ENG + (off - OFF_BLEND)/2;
                return K_BLEND;
            end
            if (eng == 0 && off >= OFF_CAPTURE && off < OFF_CAP_END) begin
                lane = off[1:0];
                return K_CAPTURE;
            end
            if (off >= OFF_BRIGHT && off < OFF_BRT_END) begin
                idx = eng;
                return K_BRIGHT;
            end
            return K_NONE;
        endfunction

        function bit [31:0] get_reg(input t_reg_kind kind, input int idx);
            case (kind)
                K_DISPCNT:   return disp_ctl[idx];
                K_BGCNT:     return bg_cnt[idx];
                K_BGHOFS:    return bg_hofs[idx];
                K_BGVOFS:    return bg_vofs[idx];
                K_AFF_COEFF: return aff_coeff[idx];
                K_AFF_REF:   return aff_ref[idx];
                K_WIN:       return win_regs[idx];
                K_BLEND:     return blend_regs[idx];
                K_CAPTURE:   return cap_ctl;
                K_BRIGHT:    return bright[idx];
                default:     return 32'h0;
            endcase
        endfunction

        function void set_reg(input t_reg_kind kind, input int idx, input bit [31:0] val);
            case (kind)
                K_DISPCNT:   disp_ctl[idx]   = val;
                K_BGCNT:     bg_cnt[idx]     = val[15:0];
                K_BGHOFS:    bg_hofs[idx]    = val[15:0];
                K_BGVOFS:    bg_vofs[idx]    = val[15:0];
                K_AFF_COEFF: aff_coeff[idx]  = val[15:0];
                K_AFF_REF:   aff_ref[idx]    = val;
                K_WIN:       win_regs[idx]   = val[15:0];
                K_BLEND:     blend_regs[idx] = val[15:0];
                K_CAPTURE:   cap_ctl         = val;
                K_BRIGHT:    bright[idx]     = val[15:0];
                default: ;
            endcase
        endfunction

        function void note_access(input bit wr, input bit [31:0] addr, input bit [7:0] data);
            t_reg_kind kind;
            int idx;
            int sh;
            bit [1:0] lane;
            bit [31:0] cur;
            bit [7:0] byte_val;
            t_exp_beat e;
            kind = decode(addr, idx, lane);
            e.addr      = addr;
            e.mapped    = (kind != K_NONE);
            e.read_byte = 8'h00;
            if (kind != K_NONE) begin
                cur = get_reg(kind, idx);
                sh  = lane * 8;
                if (wr) begin
                    byte_val = data;
                    // top byte of a reference point keeps only its low nibble
                    if (kind == K_AFF_REF && lane == REF_TOP_BYTE)
                        byte_val = byte_val & REF_TOP_MASK;
                    set_reg(kind, idx, (cur & ~(32'hFF << sh)) | (32'(byte_val) << sh));
                end else begin
                    e.read_byte = cur[sh +: 8];
                end
            end
            pending_beats.push_back(e);
        endfunction

        task check_response(input logic [7:0] rd, input logic m);
            t_exp_beat e;
            if (pending_beats.size() == 0) begin
                report($sformatf("response beat with no access pending (rd=%02h mapped=%b)", rd, m));
            end else begin
                e = pending_beats.pop_front();
                if (rd !== e.read_byte)
                    report($sformatf("addr %08h read_byte %02h, want %02h", e.addr, rd, e.read_byte));
                if (m !== e.mapped)
                    report($sformatf("addr %08h mapped %b, want %b", e.addr, m, e.mapped));
            end
        endtask

        task check_drained();
            t_exp_beat e;
            while (pending_beats.size() != 0) begin
                e = pending_beats.pop_front();
                report($sformatf("no response for access at %08h", e.addr));
            end
        endtask
    endclass

    reg_file_shadow shadow;
    int idle_mode;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // 0: back to back, 1: full random gaps, 2: mostly back to back
    function automatic int draw_idle();
        case (idle_mode)
            0:       return 0;
            1:       return $urandom_range(0, 11);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        endcase
    endfunction

    function automatic bit [31:0] pick_address();
        int sel;
        bit [19:0] page;
        bit [11:0] off;
        sel  = $urandom_range(0, 99);
        page = $urandom_range(0, 1) ? SUB_PAGE : MAIN_PAGE;
        off  = 12'($urandom_range(0, 'h6F));
        if (sel < 75)
            return {page, off};
        if (sel < 80)
            return {page, 12'($urandom_range(0, 'hFFF))};
        if (sel < 90) begin
            page = page ^ (20'd1 << $urandom_range(0, 19));
            return {page, 12'($urandom_range(0, 'hFFF))};
        end
        return $urandom();
    endfunction

    function automatic bit [7:0] pick_data();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_access(input bit wr, input bit [31:0] addr, input bit [7:0] data);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= wr;
        req_if.bus_address <= addr;
        req_if.write_byte  <= data;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic wait_drained(input int max_cycles);
        int w;
        for (w = 0; w < max_cycles && shadow.outstanding() != 0; w++)
            @(posedge i_clk);
    endtask

    // Accepted beats on both channels, sampled at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
                shadow.note_access(req_if.req_type, req_if.bus_address, req_if.write_byte);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                shadow.check_response(rsp_if.read_byte, rsp_if.mapped);
        end
    end

    // Response side back-pressure.
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        repeat (5) @(posedge i_clk);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int i;
        bit wr;
        shadow    = new();
        idle_mode = 0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= ACC_READ;
        req_if.bus_address <= 32'h0;
        req_if.write_byte  <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, byte lanes, reference point top byte, map gaps
        send_access(ACC_READ,  32'h0400_0000, 8'h00);
        send_access(ACC_WRITE, 32'h0400_0003, 8'hFF);
        send_access(ACC_READ,  32'h0400_0003, 8'hA5);
        send_access(ACC_WRITE, 32'h0400_0028, 8'hFF);
        send_access(ACC_WRITE, 32'h0400_002B, 8'hFF);
        send_access(ACC_READ,  32'h0400_002B, 8'h00);
        send_access(ACC_READ,  32'h0400_0028, 8'h00);
        send_access(ACC_WRITE, 32'h0400_103F, 8'hF3);
        send_access(ACC_READ,  32'h0400_103F, 8'h00);
        send_access(ACC_WRITE, 32'h0400_1064, 8'hAA);
        send_access(ACC_READ,  32'h0400_1064, 8'h00);
        send_access(ACC_WRITE, 32'h0400_0067, 8'h5A);
        send_access(ACC_READ,  32'h0400_0067, 8'h00);
        send_access(ACC_WRITE, 32'h0400_0004, 8'h77);
        send_access(ACC_READ,  32'h0400_0004, 8'h00);
        send_access(ACC_WRITE, 32'h0400_004C, 8'h11);
        send_access(ACC_READ,  32'h0400_0056, 8'h00);
        send_access(ACC_READ,  32'h0000_0000, 8'h00);
        send_access(ACC_WRITE, 32'hFFFF_FFFF, 8'hFF);
        send_access(ACC_READ,  32'hFFFF_FFFF, 8'h00);
        send_access(ACC_WRITE, 32'h0400_106D, 8'h80);
        send_access(ACC_READ,  32'h0400_106D, 8'h00);
        send_access(ACC_WRITE, 32'h0400_101E, 8'h01);
        send_access(ACC_READ,  32'h0400_101E, 8'h00);
        send_access(ACC_WRITE, 32'h0400_2000, 8'h33);

        for (i = 0; i < RANDOM_ACCESSES; i++) begin
            if (i % 150 == 0)
                idle_mode = $urandom_range(0, 2);
            if (i == RANDOM_ACCESSES / 2) begin
                // hold off until the response side has caught up
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                wait_drained(2000);
            end
            wr = $urandom_range(0, 1);
            send_access(wr, pick_address(), pick_data());
        end
        req_if.valid <= 1'b0;
        // let the monitor log the last accepted beat before counting what is pending
        @(posedge i_clk);

        wait_drained(2000);
        repeat (10) @(posedge i_clk);
        shadow.check_drained();
        if (shadow.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
